/* rtl/som_pkg.sv */
// Shared constants for the segmentation overlap metrics core
package som_pkg;
	localparam int PIXEL_COUNT_BITS = 20;
	localparam int FRACTION_BITS = 16;
	localparam logic [7:0] FG_VALUE = 8'd255;
endpackage

/* rtl/som_if.sv */
// Valid/ready channel interfaces for pixel items and metric items
interface som_pix_if;
	logic valid;
	logic ready;
	logic [7:0] predicted_pixel;
	logic [7:0] reference_pixel;
	logic last_pixel;
	modport source (output valid, predicted_pixel, reference_pixel, last_pixel, input ready);
	modport sink (input valid, predicted_pixel, reference_pixel, last_pixel, output ready);
endinterface

interface som_res_if;
	logic valid;
	logic ready;
	logic [20:0] true_pos;
	logic [20:0] false_pos;
	logic [20:0] false_neg;
	logic [20:0] true_neg;
	logic [20:0] mask_pos;
	logic [16:0] iou_ratio;
	logic [16:0] accuracy_ratio;
	logic [16:0] dice_ratio;
	logic [16:0] precision_ratio;
	logic [16:0] recall_ratio;
	logic [16:0] f1_ratio;
	logic [22:0] hit_percent;
	modport source (output valid, true_pos, false_pos, false_neg, true_neg, mask_pos,
		iou_ratio, accuracy_ratio, dice_ratio, precision_ratio, recall_ratio, f1_ratio,
		hit_percent, input ready);
	modport sink (input valid, true_pos, false_pos, false_neg, true_neg, mask_pos,
		iou_ratio, accuracy_ratio, dice_ratio, precision_ratio, recall_ratio, f1_ratio,
		hit_percent, output ready);
endinterface

/* rtl/segmentation_overlap_metrics_core.sv */
// Top level: confusion counts per pixel item, metrics by a shared serial divider
// Non-last pixel items: one per cycle, accepted back to back.
// Last pixel item: seven restoring divisions on one shared divider, each with a DW-bit
// quotient (DW = quotient width, 47 at defaults), then the result item.
// Input is not ready during the divisions; they start once the previous result is taken.
// arst_n clears all counters and control state.
module segmentation_overlap_metrics_core #(
	parameter int PIXEL_COUNT_BITS = som_pkg::PIXEL_COUNT_BITS,
	parameter int FRACTION_BITS = som_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	som_pix_if.sink pix,
	som_res_if.source res
);
	localparam int CW = PIXEL_COUNT_BITS + 1;
	localparam int NW = CW + 3 + 7;
	localparam int DW = NW + FRACTION_BITS;
	localparam int RW = NW + 2;
	localparam int KW = $clog2(DW + 1);
	localparam logic [CW-1:0] CAP = CW'(1) << PIXEL_COUNT_BITS;
	localparam logic [DW-1:0] ONE_Q = DW'(1) << FRACTION_BITS;

	typedef enum logic [3:0] {
		S_COUNT, S_IOU, S_ACC, S_DICE, S_PREC, S_REC, S_F1, S_HIT, S_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] tp_q, fp_q, fn_q, tn_q, rc_q;
	logic [DW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic busy_q;
	logic [DW-1:0] prec_q, rec_q;
	logic res_valid_q;

	logic [NW-1:0] op_num, op_den;
	logic [DW-1:0] op_dividend;
	logic [2*FRACTION_BITS+1:0] f1_prod;
	logic [RW-1:0] rem_sh, rem_sub;
	logic take, is_fg_p, is_fg_r;

	assign pix.ready = (state_q == S_COUNT);
	assign take = pix.valid && pix.ready;
	assign is_fg_p = pix.predicted_pixel == som_pkg::FG_VALUE;
	assign is_fg_r = pix.reference_pixel == som_pkg::FG_VALUE;
	assign res.valid = res_valid_q;

	// operands for the division that the current state starts
	always_comb begin
		op_num = '0;
		op_den = '0;
		op_dividend = '0;
		unique case (state_q)
			S_IOU: begin
				op_num = NW'(tp_q);
				op_den = NW'(tp_q) + NW'(fp_q) + NW'(fn_q);
			end
			S_ACC: begin
				op_num = NW'(tp_q) + NW'(tn_q);
				op_den = NW'(tp_q) + NW'(fp_q) + NW'(fn_q) + NW'(tn_q);
			end
			S_DICE: begin
				op_num = NW'(tp_q) << 1;
				op_den = (NW'(tp_q) << 1) + NW'(fp_q) + NW'(fn_q);
			end
			S_PREC: begin
				op_num = NW'(tp_q);
				op_den = NW'(tp_q) + NW'(fp_q);
			end
			S_REC: begin
				op_num = NW'(tp_q);
				op_den = NW'(tp_q) + NW'(fn_q);
			end
			S_F1: begin
				op_den = NW'(prec_q) + NW'(rec_q);
			end
			S_HIT: begin
				op_num = (NW'(tp_q) << 6) + (NW'(tp_q) << 5) + (NW'(tp_q) << 2);
				op_den = NW'(rc_q);
			end
			default: ;
		endcase
		f1_prod = prec_q[FRACTION_BITS:0] * rec_q[FRACTION_BITS:0];
		if (state_q == S_F1)
			op_dividend = DW'(f1_prod);
		else
			op_dividend = DW'(op_num) << FRACTION_BITS;
		rem_sh = {rem_q[RW-2:0], quo_q[DW-1]};
		rem_sub = rem_sh - RW'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COUNT;
			tp_q <= '0; fp_q <= '0; fn_q <= '0; tn_q <= '0; rc_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			prec_q <= '0;
			rec_q <= '0;
			res.true_pos <= '0;
			res.false_pos <= '0;
			res.false_neg <= '0;
			res.true_neg <= '0;
			res.mask_pos <= '0;
			res.iou_ratio <= '0;
			res.accuracy_ratio <= '0;
			res.dice_ratio <= '0;
			res.precision_ratio <= '0;
			res.recall_ratio <= '0;
			res.f1_ratio <= '0;
			res.hit_percent <= '0;
		end else begin
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_COUNT: begin
					if (take) begin
						if (is_fg_p && is_fg_r && tp_q < CAP) tp_q <= tp_q + 1'b1;
						if (pix.predicted_pixel == '0 && pix.reference_pixel == '0 && tn_q < CAP)
							tn_q <= tn_q + 1'b1;
						if (is_fg_r && rc_q < CAP) rc_q <= rc_q + 1'b1;
						if (is_fg_p && !is_fg_r && fp_q < CAP) fp_q <= fp_q + 1'b1;
						if (!is_fg_p && is_fg_r && fn_q < CAP) fn_q <= fn_q + 1'b1;
						if (pix.last_pixel) state_q <= S_IOU;
					end
				end
				S_OUT: begin
					res.true_pos <= tp_q;
					res.false_pos <= fp_q;
					res.false_neg <= fn_q;
					res.true_neg <= tn_q;
					res.mask_pos <= rc_q;
					res_valid_q <= 1'b1;
					tp_q <= '0; fp_q <= '0; fn_q <= '0; tn_q <= '0; rc_q <= '0;
					state_q <= S_COUNT;
				end
				default: begin
					if (!busy_q) begin
						// hold off while the previous result item still waits
						if (!res_valid_q) begin
							quo_q <= op_dividend;
							den_q <= op_den;
							rem_q <= '0;
							cnt_q <= KW'(DW);
							busy_q <= 1'b1;
						end
					end else if (cnt_q != '0) begin
						if (!rem_sub[RW-1]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end else begin
						busy_q <= 1'b0;
						unique case (state_q)
							S_IOU: begin
								res.iou_ratio <= 17'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_ACC;
							end
							S_ACC: begin
								res.accuracy_ratio <= 17'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_DICE;
							end
							S_DICE: begin
								res.dice_ratio <= 17'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_PREC;
							end
							S_PREC: begin
								prec_q <= den_q == '0 ? ONE_Q : quo_q;
								res.precision_ratio <= 17'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_REC;
							end
							S_REC: begin
								rec_q <= den_q == '0 ? ONE_Q : quo_q;
								res.recall_ratio <= 17'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_F1;
							end
							S_F1: begin
								// quotient of P*R/(P+R), doubled
								res.f1_ratio <= 17'(den_q == '0 ? ONE_Q :
									(quo_q << 1) + DW'((rem_q << 1) >= RW'(den_q)));
								state_q <= S_HIT;
							end
							default: begin
								res.hit_percent <= 23'(den_q == '0 ? ONE_Q : quo_q);
								state_q <= S_OUT;
							end
						endcase
					end
				end
			endcase
		end
	end
endmodule
